// ===== src/bu2x_pkg.sv =====
// Shared types, constants and arithmetic helpers of the bilinear 2x upscaler.
package bu2x_pkg;

    // Frame size limits and derived widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int STEP_W     = 15;
    localparam int OPOS_W     = SIZE_W + 1;
    localparam int FRAC_W     = 16;
    localparam int WT_W       = FRAC_W + 1;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int TOP_W      = CH_W + FRAC_W;
    localparam int BAND_ROWS  = 4;
    localparam int BAND_COLS  = 4;
    localparam int K_W        = $clog2(BAND_COLS) + 1;
    localparam logic [WT_W-1:0] FULL_WEIGHT = WT_W'(1) << FRAC_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 8'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic mem_rd;
        logic mem_wr;
        logic mem_cur;
        logic cap_p00;
        logic cap_p10;
        logic band_init;
        logic band_inc;
        logic col_place;
        logic col_mul;
        logic col_next;
        logic row_place;
        logic row_mul;
        logic flush;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sx_zero;
        logic sy_zero;
        logic band_go;
        logic col_go;
        logic row_go;
        logic hold_vld;
        logic mul_ok;
    } sts_t;

    typedef struct packed {
        logic [SIZE_W-1:0] ipart;
        logic [WT_W-1:0]   frac;
    } place_t;

    // Clamp a programmed size to the supported range.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Source integer position and fraction of an output index; past the edge it holds the last.
    function automatic place_t place(input logic [OPOS_W-1:0] idx,
                                     input logic [STEP_W-1:0] step,
                                     input logic [SIZE_W-1:0] n);
        logic [OPOS_W+STEP_W-1:0] pos;
        place_t p;
        pos = (OPOS_W+STEP_W)'(idx) * (OPOS_W+STEP_W)'(step);
        p.ipart = SIZE_W'(pos >> FRAC_W);
        p.frac = {1'b0, pos[FRAC_W-1:0]};
        if (p.ipart > n - SIZE_W'(2)) begin
            p.ipart = n - SIZE_W'(2);
            p.frac = FULL_WEIGHT;
        end
        return p;
    endfunction

    // Horizontal blend of two channel values.
    function automatic logic [TOP_W-1:0] blend_h(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [WT_W-1:0] t);
        logic [TOP_W:0] s;
        s = (TOP_W+1)'(a) * (TOP_W+1)'(FULL_WEIGHT - t) + (TOP_W+1)'(b) * (TOP_W+1)'(t);
        return s[TOP_W-1:0];
    endfunction

    // Vertical blend of two horizontal results, truncated to a channel value.
    function automatic logic [CH_W-1:0] blend_v(input logic [TOP_W-1:0] a,
                                                input logic [TOP_W-1:0] b,
                                                input logic [WT_W-1:0] t);
        logic [TOP_W+FRAC_W:0] s;
        s = (TOP_W+FRAC_W+1)'(a) * (TOP_W+FRAC_W+1)'(FULL_WEIGHT - t)
          + (TOP_W+FRAC_W+1)'(b) * (TOP_W+FRAC_W+1)'(t);
        return s[2*FRAC_W+CH_W-1:2*FRAC_W];
    endfunction

endpackage

// ===== src/bu2x_if.sv =====
// Channel interfaces: source pixels, output pixels and configuration writes.
interface bu2x_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface bu2x_pix_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        run_last;
    modport source (output valid, output out_col, output out_row, output out_red,
                    output out_green, output out_blue, output run_last, input ready);
    modport sink (input valid, input out_col, input out_row, input out_red,
                  input out_green, input out_blue, input run_last, output ready);
endinterface

interface bu2x_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bu2x_datapath.sv =====
// Datapath: registers, line store, position arithmetic, blending and output staging.
module bu2x_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bu2x_pkg::cmd_t                cmd,
    output bu2x_pkg::sts_t                sts,
    input  logic [7:0]                    in_red,
    input  logic [7:0]                    in_green,
    input  logic [7:0]                    in_blue,
    input  logic                          cfg_valid,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bu2x_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [10:0]                   out_col,
    output logic [10:0]                   out_row,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic                          run_last
);
    import bu2x_pkg::*;

    // Configuration and control registers.
    logic [SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [COL_W-1:0]  col_cnt_reg, sx_reg;
    logic [ROW_W-1:0]  row_cnt_reg, sy_reg;
    logic [OPOS_W-1:0] noc_reg, nor_reg, be_reg, r_reg;
    logic [K_W-1:0]    k_reg;
    logic              hold_vld_reg, out_vld_reg;

    // Payload registers.
    logic [PIX_W-1:0]  pix_reg, left_reg, p00_reg, p10_reg, rd_data_reg;
    logic [WT_W-1:0]   tx_reg, ty_reg;
    logic [TOP_W-1:0]  top_reg [3];
    logic [TOP_W-1:0]  bot_reg [3];
    logic [10:0]       hold_col_reg, hold_row_reg, out_col_reg, out_row_reg;
    logic [PIX_W-1:0]  hold_pix_reg, out_pix_reg;
    logic              out_last_reg;

    // Line store holding the previous source row.
    logic [PIX_W-1:0]  row_mem [MAX_WIDTH];

    logic [SIZE_W-1:0] w, h;
    logic [OPOS_W-1:0] out_cols, out_rows;
    logic [COL_W-1:0]  sx_sat, mem_addr;
    logic [ROW_W-1:0]  sy_sat;
    logic              sx_last, wr_ok, out_free;
    logic [PIX_W-1:0]  wdata, blend_pix;
    place_t            bp, cp, rp;
    logic [SIZE_W-1:0] nx, ny;

    // Effective frame size, saturated position and band checks.
    always_comb
    begin
        w        = clamp_size(src_width_reg, SIZE_W'(MAX_WIDTH));
        h        = clamp_size(src_height_reg, SIZE_W'(MAX_HEIGHT));
        out_cols = {w, 1'b0};
        out_rows = {h, 1'b0} - OPOS_W'(1);
        sx_sat   = (SIZE_W'(col_cnt_reg) < w) ? col_cnt_reg : COL_W'(w - SIZE_W'(1));
        sy_sat   = (SIZE_W'(row_cnt_reg) < h) ? row_cnt_reg : ROW_W'(h - SIZE_W'(1));
        sx_last  = (SIZE_W'(sx_reg) == w - SIZE_W'(1));
        bp       = place(be_reg, step_y_reg, h);
        cp       = place(noc_reg, step_x_reg, w);
        rp       = place(r_reg, step_y_reg, h);
        mem_addr = cmd.mem_cur ? sx_reg : sx_reg - COL_W'(1);
        wdata    = cmd.mem_cur ? pix_reg : left_reg;
        wr_ok    = cmd.mem_wr && (cmd.mem_cur ? sx_last : (sx_reg != '0));
        out_free = !out_vld_reg || out_ready;
        nx       = SIZE_W'(sx_reg) + SIZE_W'(1);
        ny       = SIZE_W'(sy_reg) + SIZE_W'(1);
        for (int c = 0; c < 3; c++)
        begin
            blend_pix[c*CH_W +: CH_W] = blend_v(top_reg[c], bot_reg[c], ty_reg);
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.sx_zero  = (sx_reg == '0);
        sts.sy_zero  = (sy_reg == '0);
        sts.band_go  = (be_reg < out_rows) && ((be_reg - nor_reg) < OPOS_W'(BAND_ROWS))
                     && (bp.ipart < SIZE_W'(sy_reg));
        sts.col_go   = (k_reg < K_W'(BAND_COLS)) && (noc_reg < out_cols)
                     && (cp.ipart < SIZE_W'(sx_reg));
        sts.row_go   = (r_reg < be_reg);
        sts.hold_vld = hold_vld_reg;
        sts.mul_ok   = !hold_vld_reg || out_free;
    end

    // Line store port: one access per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            row_mem[mem_addr] <= wdata;
        if (cmd.mem_rd)
            rd_data_reg <= row_mem[mem_addr];
    end

    // Configuration, counters and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIZE_W'(640);
            src_height_reg <= SIZE_W'(480);
            step_x_reg     <= STEP_W'(32716);
            step_y_reg     <= STEP_W'(32699);
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            noc_reg        <= '0;
            nor_reg        <= '0;
            be_reg         <= '0;
            r_reg          <= '0;
            k_reg          <= '0;
            hold_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= cfg_data[SIZE_W-1:0];
                    REG_STEP_X:     step_x_reg     <= cfg_data[STEP_W-1:0];
                    REG_STEP_Y:     step_y_reg     <= cfg_data[STEP_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.latch)
            begin
                sx_reg <= sx_sat;
                sy_reg <= sy_sat;
                k_reg  <= '0;
            end
            if (cmd.band_init)
            begin
                noc_reg <= '0;
                nor_reg <= be_reg;
            end
            if (cmd.band_inc)
                be_reg <= be_reg + OPOS_W'(1);
            if (cmd.col_mul)
                r_reg <= nor_reg;
            if (cmd.row_mul)
                r_reg <= r_reg + OPOS_W'(1);
            if (cmd.col_next)
            begin
                noc_reg <= noc_reg + OPOS_W'(1);
                k_reg   <= k_reg + K_W'(1);
            end
            // Advance the source position; the frame end clears the band state.
            if (cmd.finish)
            begin
                if (nx >= w)
                begin
                    col_cnt_reg <= '0;
                    if (ny >= h)
                    begin
                        row_cnt_reg <= '0;
                        noc_reg     <= '0;
                        nor_reg     <= '0;
                        be_reg      <= '0;
                    end
                    else
                        row_cnt_reg <= ROW_W'(ny);
                end
                else
                    col_cnt_reg <= COL_W'(nx);
            end
            // Output staging flags.
            if (cmd.row_mul)
            begin
                hold_vld_reg <= 1'b1;
                if (hold_vld_reg)
                    out_vld_reg <= 1'b1;
                else if (out_ready)
                    out_vld_reg <= 1'b0;
            end
            else if (cmd.flush && hold_vld_reg && out_free)
            begin
                hold_vld_reg <= 1'b0;
                out_vld_reg  <= 1'b1;
            end
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Pixel, window, weight and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            pix_reg <= {in_blue, in_green, in_red};
        if (cmd.cap_p00)
            p00_reg <= rd_data_reg;
        if (cmd.cap_p10)
            p10_reg <= rd_data_reg;
        if (cmd.finish)
            left_reg <= pix_reg;
        if (cmd.col_place)
            tx_reg <= cp.frac;
        if (cmd.col_mul)
        begin
            for (int c = 0; c < 3; c++)
            begin
                top_reg[c] <= blend_h(p00_reg[c*CH_W +: CH_W], p10_reg[c*CH_W +: CH_W],
                                      tx_reg);
                bot_reg[c] <= blend_h(left_reg[c*CH_W +: CH_W], pix_reg[c*CH_W +: CH_W],
                                      tx_reg);
            end
        end
        if (cmd.row_place)
            ty_reg <= rp.frac;
        if (cmd.row_mul)
        begin
            hold_col_reg <= noc_reg[10:0];
            hold_row_reg <= r_reg[10:0];
            hold_pix_reg <= blend_pix;
            if (hold_vld_reg)
            begin
                out_col_reg  <= hold_col_reg;
                out_row_reg  <= hold_row_reg;
                out_pix_reg  <= hold_pix_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (cmd.flush && hold_vld_reg && out_free)
        begin
            out_col_reg  <= hold_col_reg;
            out_row_reg  <= hold_row_reg;
            out_pix_reg  <= hold_pix_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_red   = out_pix_reg[CH_W-1:0];
    assign out_green = out_pix_reg[2*CH_W-1:CH_W];
    assign out_blue  = out_pix_reg[3*CH_W-1:2*CH_W];
    assign run_last  = out_last_reg;

endmodule

// ===== src/bu2x_ctrl.sv =====
// Controller: sequences the per-pixel store access, banding and blending steps.
module bu2x_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bu2x_pkg::sts_t sts,
    output bu2x_pkg::cmd_t cmd
);
    import bu2x_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_WR0    = 4'd3;
    localparam logic [3:0] ST_WR1    = 4'd4;
    localparam logic [3:0] ST_BINIT  = 4'd5;
    localparam logic [3:0] ST_BSTEP  = 4'd6;
    localparam logic [3:0] ST_COLCHK = 4'd7;
    localparam logic [3:0] ST_COLMUL = 4'd8;
    localparam logic [3:0] ST_ROWP   = 4'd9;
    localparam logic [3:0] ST_ROWM   = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;

    logic [3:0] state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.cap_p00 = 1'b1;
                cmd.mem_rd  = 1'b1;
                cmd.mem_cur = 1'b1;
                state_next  = ST_WR0;
            end
            ST_WR0:
            begin
                cmd.cap_p10 = 1'b1;
                cmd.mem_wr  = 1'b1;
                state_next  = ST_WR1;
            end
            ST_WR1:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.mem_cur = 1'b1;
                if (sts.sy_zero)
                    state_next = ST_FIN;
                else if (sts.sx_zero)
                    state_next = ST_BINIT;
                else
                    state_next = ST_COLCHK;
            end
            ST_BINIT:
            begin
                cmd.band_init = 1'b1;
                state_next    = ST_BSTEP;
            end
            ST_BSTEP:
            begin
                if (sts.band_go)
                    cmd.band_inc = 1'b1;
                else
                    state_next = ST_FIN;
            end
            ST_COLCHK:
            begin
                if (sts.col_go)
                begin
                    cmd.col_place = 1'b1;
                    state_next    = ST_COLMUL;
                end
                else
                    state_next = ST_FIN;
            end
            ST_COLMUL:
            begin
                cmd.col_mul = 1'b1;
                state_next  = ST_ROWP;
            end
            ST_ROWP:
            begin
                if (sts.row_go)
                begin
                    cmd.row_place = 1'b1;
                    state_next    = ST_ROWM;
                end
                else
                begin
                    cmd.col_next = 1'b1;
                    state_next   = ST_COLCHK;
                end
            end
            ST_ROWM:
            begin
                if (sts.mul_ok)
                begin
                    cmd.row_mul = 1'b1;
                    state_next  = ST_ROWP;
                end
            end
            ST_FIN:
            begin
                if (sts.hold_vld)
                    cmd.flush = 1'b1;
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/bilinear_upscale_2x_unit.sv =====
// Top level of the streaming bilinear 2x upscaler.
// Source RGB pixels enter in raster order, one transaction each, and every pixel that closes
// a 2x2 source window emits the output pixels of its band, each tagged with its column and
// row, with run_last on the final one. One pixel is handled at a time by a sequencer over a
// single-port line store: each pixel is accepted, read twice, passes two write steps and
// finishes; a pixel at column zero of a later row adds a band set-up step and a band step per
// new band row; any other pixel adds a column check, column blend and row check per emitted
// column, a row weight and row blend step per output row, and a closing column check and
// flush. The output side can stall the row blend and flush steps. Results pass through a hold
// register and an output register. The line store needs no clearing after reset.
module bilinear_upscale_2x_unit (
    input  logic           clk,
    input  logic           rst_n,
    bu2x_pix_in_if.sink    pix_in,
    bu2x_pix_out_if.source pix_out,
    bu2x_cfg_if.sink       cfg
);
    import bu2x_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // Sequencer.
    bu2x_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    bu2x_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_red    (pix_in.in_red),
        .in_green  (pix_in.in_green),
        .in_blue   (pix_in.in_blue),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_col   (pix_out.out_col),
        .out_row   (pix_out.out_row),
        .out_red   (pix_out.out_red),
        .out_green (pix_out.out_green),
        .out_blue  (pix_out.out_blue),
        .run_last  (pix_out.run_last)
    );

endmodule
